// ===== rtl/core/lrg_pkg.sv =====
`default_nettype none
package lrg_pkg;
  localparam int unsigned FullTurn = 3600000;
  localparam int unsigned QuarterTurn = 900000;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned AngW = 22;
  localparam int unsigned ZW = 22;
  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CW-1:0] OneQ30 = 34'sd1073741824;

  typedef enum logic [1:0] {
    CFG_MOUNT_HEIGHT = 2'd0,
    CFG_OFFSET_FWD   = 2'd1,
    CFG_OFFSET_LAT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POSE_TRIG, ST_POSE_MUL, ST_POSE_SUM,
    ST_BEAM_TRIG, ST_HEAD_TRIG, ST_MUL_V, ST_MUL_H, ST_MUL_XY, ST_OUT
  } state_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 22'd450000;  5'd1: r = 22'd265651;  5'd2: r = 22'd140362;
        5'd3: r = 22'd71250;   5'd4: r = 22'd35763;   5'd5: r = 22'd17899;
        5'd6: r = 22'd8952;    5'd7: r = 22'd4476;    5'd8: r = 22'd2238;
        5'd9: r = 22'd1119;    5'd10: r = 22'd560;    5'd11: r = 22'd280;
        5'd12: r = 22'd140;    5'd13: r = 22'd70;     5'd14: r = 22'd35;
        5'd15: r = 22'd17;     5'd16: r = 22'd9;      5'd17: r = 22'd4;
        5'd18: r = 22'd2;      5'd19: r = 22'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [AngW-1:0] reduce_angle(input logic [AngW-1:0] a);
    begin
      return (a >= AngW'(FullTurn)) ? AngW'(a - AngW'(FullTurn)) : a;
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/lidar_range_georeference.sv =====
// Each accepted sample runs the beam-angle CORDIC, the heading CORDIC and the multiply
// states to its point; on a scan start, heading CORDIC and pose update run first.
// A new sample is taken only in the idle state; the time per sample is set by the
// iterative 20-step CORDIC, run for beam angle, then heading (and pose on a scan start).
// The output register holds a waiting point, so the next sample is taken meanwhile.
// Synchronous active-low reset clears state, pose and configuration to zero.
`default_nettype none
module lidar_range_georeference import lrg_pkg::*; #(
  parameter int unsigned TRIG_FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_scan_start,
  input  wire logic [21:0]        in_start_angle,
  input  wire logic [21:0]        in_angular_step,
  input  wire logic [29:0]        in_vehicle_easting,
  input  wire logic [33:0]        in_vehicle_northing,
  input  wire logic [21:0]        in_vehicle_heading,
  input  wire logic [15:0]        in_range_mm,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [30:0]      out_point_x,
  output logic signed [34:0]      out_point_y,
  output logic signed [17:0]      out_point_z
);
  localparam int unsigned TW = TRIG_FRACTION_BITS + 2;
  localparam int unsigned PW = 56;
  localparam int unsigned F = TRIG_FRACTION_BITS;

  state_t               st_r, st_nxt;
  logic [15:0]          mh_r;
  logic signed [15:0]   of_r, ol_r;
  logic [AngW-1:0]      ba_r, bs_r, hd_r;
  logic signed [31:0]   se_r;
  logic signed [34:0]   sn_r;
  logic [15:0]          d_r;
  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [PW-1:0] h_r;
  logic signed [TW-1:0] sb_r, cb_r;
  logic                 ov_r;
  logic signed [30:0]   px_r;
  logic signed [34:0]   py_r;
  logic signed [17:0]   pz_r;
  logic                 c_start, c_done;
  logic [AngW-1:0]      c_ang;
  logic signed [TW-1:0] c_s, c_c;
  logic [AngW:0]        ba_sum;
  logic signed [PW-1:0] dd, rnd;

  lrg_cordic #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .angle(c_ang),
    .done(c_done), .sin_o(c_s), .cos_o(c_c)
  );

  function automatic logic signed [PW-1:0] rnd_prod(input logic signed [PW-1:0] v);
    begin
      return (v + (PW'(1) <<< (F - 1))) >>> F;
    end
  endfunction

  function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v,
                                               input int unsigned b);
    logic signed [PW-1:0] hi, lo;
    begin
      hi = (PW'(1) <<< (b - 1)) - PW'(1);
      lo = -hi - PW'(1);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    end
  endfunction

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign dd = $signed({{(PW-16){1'b0}}, d_r});
  assign rnd = rnd_prod(p0_r + p1_r);
  assign ba_sum = {1'b0, ba_r} + {1'b0, bs_r};

  always_comb begin
    st_nxt = st_r; c_start = 1'b0; c_ang = hd_r;
    case (st_r)
      ST_IDLE: if (in_valid && in_ready) begin
        c_start = 1'b1;
        if (in_scan_start) begin
          c_ang = reduce_angle(in_vehicle_heading); st_nxt = ST_POSE_TRIG;
        end else begin
          c_ang = ba_r; st_nxt = ST_BEAM_TRIG;
        end
      end
      ST_POSE_TRIG: if (c_done) st_nxt = ST_POSE_MUL;
      ST_POSE_MUL: st_nxt = ST_POSE_SUM;
      ST_POSE_SUM: begin c_start = 1'b1; c_ang = ba_r; st_nxt = ST_BEAM_TRIG; end
      ST_BEAM_TRIG: if (c_done) begin
        c_start = 1'b1; c_ang = hd_r; st_nxt = ST_HEAD_TRIG;
      end
      ST_HEAD_TRIG: if (c_done) st_nxt = ST_MUL_V;
      ST_MUL_V: st_nxt = ST_MUL_H;
      ST_MUL_H: st_nxt = ST_MUL_XY;
      ST_MUL_XY: st_nxt = ST_OUT;
      ST_OUT: if (!ov_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0;
      mh_r <= '0; of_r <= '0; ol_r <= '0;
      ba_r <= '0; bs_r <= '0; hd_r <= '0; se_r <= '0; sn_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MOUNT_HEIGHT: mh_r <= cfg_data;
          CFG_OFFSET_FWD:   of_r <= cfg_data;
          CFG_OFFSET_LAT:   ol_r <= cfg_data;
          default: ;
        endcase
      end
      if (st_r == ST_OUT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (st_r == ST_IDLE && in_valid && in_ready && in_scan_start) begin
        ba_r <= reduce_angle(in_start_angle);
        bs_r <= reduce_angle(in_angular_step);
        hd_r <= reduce_angle(in_vehicle_heading);
        se_r <= 32'(in_vehicle_easting);
        sn_r <= 35'(in_vehicle_northing);
      end
      case (st_r)
        ST_POSE_TRIG: if (c_done) begin
          p0_r <= PW'(of_r) * PW'(c_s);
          p1_r <= PW'(ol_r) * PW'(c_c);
        end
        ST_POSE_MUL: begin
          sn_r <= 35'(sat(PW'(sn_r) + rnd, 35));
          p0_r <= PW'(of_r) * PW'(c_c);
          p1_r <= -(PW'(ol_r) * PW'(c_s));
        end
        ST_POSE_SUM: se_r <= 32'(sat(PW'(se_r) + rnd, 32));
        ST_BEAM_TRIG: if (c_done) begin sb_r <= c_s; cb_r <= c_c; end
        ST_MUL_V: begin
          pz_r <= 18'(sat(PW'(mh_r) - rnd_prod(dd * PW'(cb_r)), 18));
          h_r <= rnd_prod(dd * PW'(sb_r));
        end
        ST_MUL_H: begin
          p0_r <= h_r * PW'(c_c);
          p1_r <= h_r * PW'(c_s);
        end
        ST_MUL_XY: begin
          px_r <= 31'(sat(PW'(se_r) + rnd_prod(p0_r), 31));
          py_r <= 35'(sat(PW'(sn_r) + rnd_prod(p1_r), 35));
          ba_r <= (ba_sum >= (AngW+1)'(FullTurn)) ? AngW'(ba_sum - (AngW+1)'(FullTurn))
                                                   : AngW'(ba_sum);
        end
        ST_OUT: if (!ov_r || out_ready) begin
          out_point_x <= px_r; out_point_y <= py_r; out_point_z <= pz_r;
        end
        default: ;
      endcase
      if (st_r == ST_IDLE && in_valid && in_ready) d_r <= in_range_mm;
    end
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

// ===== rtl/core/lrg_cordic.sv =====
`default_nettype none
// One CORDIC micro-rotation per cycle; 20 steps, then a quadrant fold, then done.
module lrg_cordic import lrg_pkg::*; #(
  parameter int unsigned TRIG_FRACTION_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [AngW-1:0]                 angle,
  output logic                                 done,
  output logic signed [TRIG_FRACTION_BITS+1:0] sin_o,
  output logic signed [TRIG_FRACTION_BITS+1:0] cos_o
);
  localparam int unsigned TW = TRIG_FRACTION_BITS + 2;
  localparam int unsigned Sh = 30 - TRIG_FRACTION_BITS;

  logic                  busy_r, busy_nxt, fin_r, fin_nxt;
  logic [4:0]            step_r, step_nxt;
  logic [1:0]            quad_r, quad_nxt;
  logic signed [CW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW:0]    z_r, z_nxt;
  logic signed [TW-1:0]  s_r, s_nxt, c_r, c_nxt;
  logic [AngW-1:0]       a_red, rem;
  logic [1:0]            q;
  logic signed [CW-1:0]  dx, dy, ry, rx;
  logic signed [TW-1:0]  sr, cr;

  function automatic logic signed [TW-1:0] to_trig(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] c, t;
    begin
      c = (v < 0) ? '0 : ((v > OneQ30) ? OneQ30 : v);
      t = (c + (CW'(1) <<< (Sh - 1))) >>> Sh;
      return TW'(t);
    end
  endfunction

  always_comb begin
    a_red = reduce_angle(angle);
    if (a_red >= AngW'(3 * QuarterTurn)) begin
      q = 2'd3; rem = AngW'(a_red - AngW'(3 * QuarterTurn));
    end else if (a_red >= AngW'(2 * QuarterTurn)) begin
      q = 2'd2; rem = AngW'(a_red - AngW'(2 * QuarterTurn));
    end else if (a_red >= AngW'(QuarterTurn)) begin
      q = 2'd1; rem = AngW'(a_red - AngW'(QuarterTurn));
    end else begin
      q = 2'd0; rem = a_red;
    end
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    busy_nxt = busy_r; fin_nxt = 1'b0; step_nxt = step_r; quad_nxt = quad_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; s_nxt = s_r; c_nxt = c_r;
    ry = y_r; rx = x_r;
    sr = to_trig(ry); cr = to_trig(rx);
    if (start) begin
      busy_nxt = 1'b1; step_nxt = '0; quad_nxt = q;
      x_nxt = CordicGain; y_nxt = '0; z_nxt = {1'b0, rem};
    end else if (busy_r) begin
      if (!z_r[ZW]) begin
        x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - $signed({1'b0, atan_lut(step_r)});
      end else begin
        x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + $signed({1'b0, atan_lut(step_r)});
      end
      step_nxt = step_r + 5'd1;
      if (step_r == 5'(CordicSteps - 1)) begin
        busy_nxt = 1'b0; fin_nxt = 1'b1;
      end
    end else if (fin_r) begin
      case (quad_r)
        2'd0: begin s_nxt = sr;  c_nxt = cr;  end
        2'd1: begin s_nxt = cr;  c_nxt = -sr; end
        2'd2: begin s_nxt = -sr; c_nxt = -cr; end
        default: begin s_nxt = -cr; c_nxt = sr; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; fin_r <= 1'b0; done <= 1'b0;
    end else begin
      busy_r <= busy_nxt; fin_r <= fin_nxt; done <= fin_r;
    end
    step_r <= step_nxt; quad_r <= quad_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; s_r <= s_nxt; c_r <= c_nxt;
  end

  assign sin_o = s_r;
  assign cos_o = c_r;
endmodule
`default_nettype wire
